// ===== src/gmlse_pkg.sv =====
// Package with the constants, types and exponent table of the Gaussian mixture log-sum-exp unit.
package gmlse_pkg;

  localparam int NUM_COMPONENTS = 4;
  localparam int EXP_TABLE_BITS = 8;
  localparam int NUM_REGS = 4;
  localparam int NUM_ACTIVE = (NUM_COMPONENTS < NUM_REGS) ? NUM_COMPONENTS : NUM_REGS;
  localparam int TABLE_SIZE = 1 << EXP_TABLE_BITS;
  localparam int NUM_STAGES = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int X_W = 16;
  localparam int LOGP_W = 24;
  localparam int EXPSUM_W = 15;
  localparam int LUT_W = 17;
  localparam int U_W = 25;
  localparam int TERM_W = 13;
  localparam int SUM_W = TERM_W + $clog2(NUM_REGS + 1);

  localparam logic signed [LOGP_W-1:0] LOGP_MIN = {1'b1, {(LOGP_W-1){1'b0}}};
  localparam logic signed [LOGP_W-1:0] LOGP_MAX = {1'b0, {(LOGP_W-1){1'b1}}};
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [63:0] LN2_Q30 = 64'd744261118;
  localparam logic [EXPSUM_W-1:0] EXPSUM_MAX = {EXPSUM_W{1'b1}};
  localparam logic [EXPSUM_W-1:0] EXP_ONE = EXPSUM_W'(4096);
  localparam logic [12:0] EXP_SHIFT_LIMIT = 13'd20;

  typedef logic [TABLE_SIZE-1:0][LUT_W-1:0] exp_lut_t;

  // Entry j holds 2^(-j/TABLE_SIZE) in Q16, from a truncated Taylor series of exp(-x).
  function automatic exp_lut_t build_exp_lut();
    exp_lut_t lut;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    lut = '0;
    for (int j = 0; j < TABLE_SIZE; j++) begin
      x = (64'(j) * LN2_Q30) >> EXP_TABLE_BITS;
      term = 64'd1 << 30;
      sum = 64'd1 << 30;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * x) >> 30) / 64'(n);
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      lut[j] = LUT_W'((sum + 64'd8192) >> 14);
    end
    return lut;
  endfunction

  localparam exp_lut_t EXP_LUT = build_exp_lut();

endpackage

// ===== src/gaussian_mixture_log_sum_exp_unit.sv =====
// Gaussian mixture log-probability, maximum and exponent sum over a stream of pixel words.
// An accepted input word passes through eight registered stages before its result word is valid.
// Throughput: one word per cycle while out_ready is high; each of the eight stages holds its own word and
// a stage advances whenever the stage after it is empty or advancing.
// Reset: rst clears the stage valid bits and the four component registers to zero.
// The exponent table is a constant and needs no fill after reset.
module gaussian_mixture_log_sum_exp_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [gmlse_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [gmlse_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [gmlse_pkg::X_W-1:0]              intensity,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [gmlse_pkg::LOGP_W-1:0]    logp_0,
  output logic signed [gmlse_pkg::LOGP_W-1:0]    logp_1,
  output logic signed [gmlse_pkg::LOGP_W-1:0]    logp_2,
  output logic signed [gmlse_pkg::LOGP_W-1:0]    logp_3,
  output logic signed [gmlse_pkg::LOGP_W-1:0]    max_logp,
  output logic [gmlse_pkg::EXPSUM_W-1:0]         exp_sum
);

  localparam int NR = gmlse_pkg::NUM_REGS;
  localparam int NS = gmlse_pkg::NUM_STAGES;
  localparam int LW = gmlse_pkg::LOGP_W;

  logic [63:0] comp [NR];

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic [15:0]          s1_ad [NR];
  logic [31:0]          s2_sq [NR];
  logic [31:0]          s3_q [NR];
  logic signed [LW-1:0] s4_lp [NR];
  logic signed [LW-1:0] s5_lp [NR];
  logic signed [LW-1:0] s5_mx;
  logic signed [LW-1:0] s6_lp [NR];
  logic signed [LW-1:0] s6_mx;
  logic [gmlse_pkg::U_W-1:0] s6_u [NR];
  logic signed [LW-1:0] s7_lp [NR];
  logic signed [LW-1:0] s7_mx;
  logic [gmlse_pkg::TERM_W-1:0] s7_term [NR];
  logic signed [LW-1:0] s8_lp [NR];
  logic signed [LW-1:0] s8_mx;
  logic [gmlse_pkg::EXPSUM_W-1:0] s8_sum;

  logic [15:0]          ad_next [NR];
  logic signed [LW-1:0] lp_next [NR];
  logic signed [LW-1:0] mx_next;
  logic [gmlse_pkg::U_W-1:0] u_next [NR];
  logic [gmlse_pkg::TERM_W-1:0] term_next [NR];
  logic [gmlse_pkg::EXPSUM_W-1:0] sum_next;
  logic max_hit;

  // Component registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NR; k++) begin
        comp[k] <= '0;
      end
    end else if (cfg_we && (32'(cfg_index) < NR)) begin
      comp[cfg_index[$clog2(NR)-1:0]] <= cfg_data;
    end
  end

  // Stage enables: a stage loads when it is empty or its word moves on.
  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // Stage 1: distance from each mean.
  always_comb begin
    logic signed [16:0] d;
    for (int k = 0; k < NR; k++) begin
      d = $signed({1'b0, intensity}) - $signed({1'b0, comp[k][15:0]});
      ad_next[k] = d[16] ? 16'(-d) : d[15:0];
    end
  end

  // Stage 4: offset minus quadratic term, saturated.
  always_comb begin
    logic signed [33:0] v;
    for (int k = 0; k < NR; k++) begin
      v = {{2{comp[k][63]}}, comp[k][63:32]} - $signed({2'b00, s3_q[k]});
      if (v > 34'(gmlse_pkg::LOGP_MAX)) begin
        lp_next[k] = gmlse_pkg::LOGP_MAX;
      end else if (v < 34'(gmlse_pkg::LOGP_MIN)) begin
        lp_next[k] = gmlse_pkg::LOGP_MIN;
      end else begin
        lp_next[k] = v[LW-1:0];
      end
      if (k >= gmlse_pkg::NUM_ACTIVE) begin
        lp_next[k] = '0;
      end
    end
  end

  // Stage 5: maximum over the active components.
  always_comb begin
    mx_next = gmlse_pkg::LOGP_MIN;
    for (int k = 0; k < gmlse_pkg::NUM_ACTIVE; k++) begin
      if (s4_lp[k] > mx_next) begin
        mx_next = s4_lp[k];
      end
    end
  end

  // Stage 6: distance below the maximum, scaled to base two.
  always_comb begin
    logic [LW-1:0] t;
    logic [LW+16:0] p;
    for (int k = 0; k < NR; k++) begin
      t = LW'(s5_mx - s5_lp[k]);
      p = (LW+17)'(t) * (LW+17)'(gmlse_pkg::LOG2E_Q16);
      u_next[k] = p[LW+16:16];
    end
  end

  // Stage 7: table lookup for the fraction and a rounded shift for the integer part.
  always_comb begin
    logic [12:0] ip;
    logic [11:0] fp;
    logic [gmlse_pkg::LUT_W-1:0] e;
    logic [24:0] rnd;
    for (int k = 0; k < NR; k++) begin
      ip = s6_u[k][24:12];
      fp = s6_u[k][11:0];
      e = gmlse_pkg::EXP_LUT[fp[11 -: gmlse_pkg::EXP_TABLE_BITS]];
      rnd = 25'(e) + (25'd1 << (5'(ip) + 5'd3));
      term_next[k] = gmlse_pkg::TERM_W'(rnd >> (5'(ip) + 5'd4));
      if ((ip > gmlse_pkg::EXP_SHIFT_LIMIT) || (k >= gmlse_pkg::NUM_ACTIVE)) begin
        term_next[k] = '0;
      end
    end
  end

  // Stage 8: sum of the terms, saturated.
  always_comb begin
    logic [gmlse_pkg::SUM_W-1:0] acc;
    acc = '0;
    for (int k = 0; k < NR; k++) begin
      acc = acc + gmlse_pkg::SUM_W'(s7_term[k]);
    end
    if (acc > gmlse_pkg::SUM_W'(gmlse_pkg::EXPSUM_MAX)) begin
      sum_next = gmlse_pkg::EXPSUM_MAX;
    end else begin
      sum_next = acc[gmlse_pkg::EXPSUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NR; k++) begin
      if (en[0]) begin
        s1_ad[k] <= ad_next[k];
      end
      if (en[1]) begin
        s2_sq[k] <= 32'(s1_ad[k]) * 32'(s1_ad[k]);
      end
      if (en[2]) begin
        s3_q[k] <= 32'((48'(s2_sq[k]) * 48'(comp[k][31:16])) >> 16);
      end
      if (en[3]) begin
        s4_lp[k] <= lp_next[k];
      end
      if (en[4]) begin
        s5_lp[k] <= s4_lp[k];
      end
      if (en[5]) begin
        s6_lp[k] <= s5_lp[k];
        s6_u[k] <= u_next[k];
      end
      if (en[6]) begin
        s7_lp[k] <= s6_lp[k];
        s7_term[k] <= term_next[k];
      end
      if (en[7]) begin
        s8_lp[k] <= s7_lp[k];
      end
    end
    if (en[4]) begin
      s5_mx <= mx_next;
    end
    if (en[5]) begin
      s6_mx <= s5_mx;
    end
    if (en[6]) begin
      s7_mx <= s6_mx;
    end
    if (en[7]) begin
      s8_mx <= s7_mx;
      s8_sum <= sum_next;
    end
  end

  assign out_valid = vld[NS-1];
  assign logp_0 = s8_lp[0];
  assign logp_1 = s8_lp[1];
  assign logp_2 = s8_lp[2];
  assign logp_3 = s8_lp[3];
  assign max_logp = s8_mx;
  assign exp_sum = s8_sum;

  always_comb begin
    max_hit = 1'b0;
    for (int k = 0; k < gmlse_pkg::NUM_ACTIVE; k++) begin
      if (s8_lp[k] == s8_mx) begin
        max_hit = 1'b1;
      end
    end
  end

  // The component at the maximum always adds exactly one to the sum.
  a_sum_at_least_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (exp_sum >= gmlse_pkg::EXP_ONE))
    else $error("exp_sum below one");

  a_max_is_member: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> max_hit)
    else $error("max_logp matches no component");

  // An empty last stage lets every stage advance, so the input must be open.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !vld[NS-1] |-> in_ready)
    else $error("input blocked with an empty output stage");

  a_accept_loads_stage: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted word missing from first stage");

endmodule
